// ===== hw/rtl/fplmq_pkg.sv =====
// Shared types and constants of the five-level priority message queue.
package fplmq_pkg;

  localparam int ENTRY_W = 24;
  localparam int CNT_W   = 7;
  localparam int MAX_POP = 64;

  typedef enum logic [1:0] {
    ACT_SEND     = 2'd0,
    ACT_ANNOUNCE = 2'd1,
    ACT_PROMOTE  = 2'd2,
    ACT_PURGE    = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [7:0]        sender_id;
    logic [2:0]        level;
    logic [15:0]       payload;
    logic [CNT_W-1:0]  count;
  } req_word_t;

  typedef struct packed {
    logic [7:0]  out_sender;
    logic [2:0]  out_level;
    logic [15:0] out_payload;
    logic        last;
  } rsp_word_t;

endpackage

// ===== hw/rtl/fplmq_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module fplmq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/five_level_priority_message_queue_unit.sv =====
// Top level of the strict-priority multi-level message queue.
//
// The block keeps LEVELS FIFO queues of QUEUE_DEPTH entries each in one RAM.
// A send word is taken while the block is idle. An announce steps past each
// empty level and reads each popped word from the RAM, limited by the RAM read
// latency and by how fast the consumer takes results. Promote and purge walk
// every stored entry of the affected levels with a read state (S_RD) and a
// write-back state (S_CHK) each, so a walk covers up to LEVELS * QUEUE_DEPTH
// entries when all queues are full. No clearing pass is needed after reset.
module five_level_priority_message_queue_unit #(
  parameter int LEVELS      = 5,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fplmq_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output fplmq_pkg::rsp_word_t rsp
);
  import fplmq_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + 1;
  localparam int DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE, A_FIND, A_DATA, S_START, S_RD, S_CHK, S_NEXT
  } state_t;

  state_t state;
  logic [PW-1:0] head [LEVELS];
  logic [FW-1:0] fill [LEVELS];
  logic [TW-1:0] total;
  logic [CNT_W-1:0] cnt, produced;
  logic [LW-1:0] lvl;
  logic promote;
  logic [7:0] key;
  logic [FW-1:0] idx, num, kept;
  logic [PW-1:0] rd_pos, wr_pos;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic accept, send_ok, load, last_pop, match, up_ok;
  logic [LW-1:0] req_lvl, up;

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
    addr = AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] push_pos(input logic [PW-1:0] h, input logic [FW-1:0] f);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(f);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    push_pos = s[PW-1:0];
  endfunction

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign req_lvl   = LW'(req.level);
  assign send_ok   = (32'(req.level) < LEVELS) && (fill[req_lvl] < FW'(QUEUE_DEPTH));
  assign load      = !rsp_valid || rsp_ready;
  assign last_pop  = (produced + CNT_W'(1) == cnt) || (total == TW'(1));
  assign match     = (ram_rdata[23:16] == key);
  assign up        = lvl + LW'(1);
  assign up_ok     = fill[up] < FW'(QUEUE_DEPTH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      IDLE: begin
        if (accept && req.action == ACT_SEND && send_ok) begin
          ram_we    = 1'b1;
          ram_waddr = addr(req_lvl, push_pos(head[req_lvl], fill[req_lvl]));
          ram_wdata = {req.sender_id, req.payload};
        end
      end
      A_FIND: begin
        ram_re    = (fill[lvl] != '0);
        ram_raddr = addr(lvl, head[lvl]);
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr(lvl, rd_pos);
      end
      S_CHK: begin
        if (!match) begin
          ram_we    = 1'b1;
          ram_waddr = addr(lvl, wr_pos);
        end else if (promote && up_ok) begin
          ram_we    = 1'b1;
          ram_waddr = addr(up, push_pos(head[up], fill[up]));
        end
      end
      default: ;
    endcase
  end

  fplmq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      total     <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        fill[l] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready && state != A_DATA) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            key <= req.sender_id;
            unique case (req.action)
              ACT_SEND: begin
                if (send_ok) begin
                  fill[req_lvl] <= fill[req_lvl] + FW'(1);
                  total         <= total + TW'(1);
                end
              end
              ACT_ANNOUNCE: begin
                cnt      <= (req.count > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : req.count;
                produced <= '0;
                lvl      <= LW'(LEVELS - 1);
                if (req.count != '0 && total != '0) begin
                  state <= A_FIND;
                end
              end
              ACT_PROMOTE: begin
                promote <= 1'b1;
                lvl     <= LW'(LEVELS - 2);
                state   <= S_START;
              end
              ACT_PURGE: begin
                promote <= 1'b0;
                lvl     <= LW'(LEVELS - 1);
                state   <= S_START;
              end
            endcase
          end
        end
        A_FIND: begin
          if (fill[lvl] != '0) begin
            state <= A_DATA;
          end else begin
            lvl <= lvl - LW'(1);
          end
        end
        A_DATA: begin
          if (load) begin
            rsp_valid       <= 1'b1;
            rsp.out_sender  <= ram_rdata[23:16];
            rsp.out_level   <= 3'(lvl);
            rsp.out_payload <= ram_rdata[15:0];
            rsp.last        <= last_pop;
            head[lvl]       <= wrap_inc(head[lvl]);
            fill[lvl]       <= fill[lvl] - FW'(1);
            total           <= total - TW'(1);
            produced        <= produced + CNT_W'(1);
            state           <= last_pop ? IDLE : A_FIND;
          end
        end
        S_START: begin
          num    <= fill[lvl];
          idx    <= '0;
          kept   <= '0;
          rd_pos <= head[lvl];
          wr_pos <= head[lvl];
          state  <= (fill[lvl] == '0) ? S_NEXT : S_RD;
        end
        S_RD: begin
          rd_pos <= wrap_inc(rd_pos);
          state  <= S_CHK;
        end
        S_CHK: begin
          if (!match) begin
            kept   <= kept + FW'(1);
            wr_pos <= wrap_inc(wr_pos);
          end else if (promote && up_ok) begin
            fill[up] <= fill[up] + FW'(1);
          end else begin
            total <= total - TW'(1);
          end
          idx <= idx + FW'(1);
          if (idx + FW'(1) == num) begin
            fill[lvl] <= match ? kept : kept + FW'(1);
            state     <= S_NEXT;
          end else begin
            state <= S_RD;
          end
        end
        S_NEXT: begin
          if (lvl == '0) begin
            state <= IDLE;
          end else begin
            lvl   <= lvl - LW'(1);
            state <= S_START;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_find_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == A_FIND) |-> (total != '0))
    else $error("announce searching with all queues empty");

  a_pop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == A_DATA) |-> (produced < cnt))
    else $error("announce popped more words than requested");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (idx < num) && (kept <= idx))
    else $error("level walk index out of range");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_CHK) |-> !req_ready)
    else $error("request taken during a level walk");

endmodule
